@@ sv/bounded_deque_with_indexed_access_defines.svh @@
// Assertion macros shared by the deque RTL.
`ifndef BOUNDED_DEQUE_WITH_INDEXED_ACCESS_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_INDEXED_ACCESS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bdq_pkg.sv @@
// Package: operation and status codes, cell control struct.
`default_nettype none
package bdq_pkg;

  localparam int WORD_W   = 32;
  localparam int MODE_W   = 3;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_READ       = 3'd4,
    MODE_REMOVE     = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Broadcast command to every cell; at most one flag is set per beat
  typedef struct packed {
    logic shr;  // take the word of the left neighbor (push at front)
    logic shl;  // take the word of the right neighbor at and after start
    logic wr;   // load the pushed word at the write position
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ sv/bdq_in_if.sv @@
// Input channel: one operation beat.
`default_nettype none
interface bdq_in_if import bdq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic signed [WORD_W-1:0]   value;
  logic [INDEX_W-1:0]         index;

  modport source (output valid, mode, value, index, input ready);
  modport sink   (input valid, mode, value, index, output ready);
endinterface
`default_nettype wire

@@ sv/bdq_out_if.sv @@
// Result channel: one result beat.
`default_nettype none
interface bdq_out_if import bdq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [WORD_W-1:0]   data;
  logic [STATUS_W-1:0]        status;
  logic [COUNT_W-1:0]         count;

  modport source (output valid, data, status, count, input ready);
  modport sink   (input valid, data, status, count, output ready);
endinterface
`default_nettype wire

@@ sv/bdq_cell.sv @@
// One storage cell of the deque row; logical position is fixed per cell.
`default_nettype none
module bdq_cell import bdq_pkg::*; #(
  parameter int             PW  = 4,
  parameter logic [PW-1:0]  POS = '0
) (
  input  wire logic                     clk,
  input  wire cell_ctl_t                ctl,
  input  wire logic [PW-1:0]            start,
  input  wire logic [PW-1:0]            wpos,
  input  wire logic signed [WORD_W-1:0] value,
  input  wire logic signed [WORD_W-1:0] left_q,
  input  wire logic signed [WORD_W-1:0] right_q,
  output logic signed [WORD_W-1:0]      q
);

  // Shift toward the back, close a gap toward the front, or load a push
  always_ff @(posedge clk) begin
    if (ctl.shr) begin
      q <= left_q;
    end else if (ctl.shl && (POS >= start)) begin
      q <= right_q;
    end else if (ctl.wr && (POS == wpos)) begin
      q <= value;
    end
  end

endmodule
`default_nettype wire

@@ sv/bounded_deque_with_indexed_access.sv @@
// Top level: bounded deque of signed words with indexed read and remove.
//
// Usage:
//   in_bus carries one operation per beat (mode, value, index); out_bus
//   returns exactly one result per operation (data, status, count).
//   Elements sit in a row of DEPTH cells in logical order, cell 0 being
//   the front. Push at front and pop at front shift the whole row by one
//   cell; remove shifts every cell from the index onward toward the front.
//   Push at back writes the cell at the current count.
//   The result is registered and appears in the cycle after the operation beat.
//   Throughput: one operation per cycle while out_bus is not stalled; the cell row updates
//   in the same cycle the beat is taken and the result is held in an output register.
//   in_bus.ready stays high while the output register is empty or being
//   drained; a stalled receiver stops new beats until it takes the result.
//   Reset (rst_n low, synchronous) empties the deque and drops any pending
//   result; cell contents are not cleared and are never read before written.
`default_nettype none
`include "bounded_deque_with_indexed_access_defines.svh"
module bounded_deque_with_indexed_access import bdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bdq_in_if.sink    in_bus,
  bdq_out_if.source out_bus
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  logic                      out_valid_r;
  logic signed [WORD_W-1:0]  out_data_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [COUNT_W-1:0]        out_count_r;

  logic                      fire;
  logic                      full;
  logic                      empty;
  logic                      in_range;
  cell_ctl_t                 ctl;
  logic [PW-1:0]             start;
  logic [PW-1:0]             wpos;
  logic [PW-1:0]             rd_pos;
  logic                      rd_en;
  status_t                   status;
  logic signed [WORD_W-1:0]  rd_data;
  logic signed [WORD_W-1:0]  cell_q [DEPTH];

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign fire         = in_bus.valid && in_bus.ready;
  assign full         = (count_r == CW'(DEPTH));
  assign empty        = (count_r == '0);
  assign in_range     = (32'(in_bus.index) < 32'(count_r));

  // Decode the operation into a cell command and a read select
  always_comb begin
    ctl       = '0;
    start     = '0;
    wpos      = PW'(count_r);
    rd_pos    = '0;
    rd_en     = 1'b0;
    status    = ST_OK;
    count_nxt = count_r;
    unique case (mode_t'(in_bus.mode))
      MODE_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.wr    = fire;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.shr   = fire;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_pos    = PW'(count_r - 1'b1);
          count_nxt = count_r - 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          ctl.shl   = fire;
          count_nxt = count_r - 1'b1;
        end
      end
      MODE_READ: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          rd_en  = 1'b1;
          rd_pos = PW'(in_bus.index);
        end
      end
      MODE_REMOVE: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          rd_en     = 1'b1;
          rd_pos    = PW'(in_bus.index);
          start     = PW'(in_bus.index);
          ctl.shl   = fire;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_data = rd_en ? cell_q[rd_pos] : '0;

  // Row of cells; the front cell takes the pushed word on a front shift
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    bdq_cell #(
      .PW  (PW),
      .POS (PW'(g))
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .start   (start),
      .wpos    (wpos),
      .value   (in_bus.value),
      .left_q  ((g == 0) ? in_bus.value : cell_q[(g == 0) ? 0 : g - 1]),
      .right_q ((g == DEPTH - 1) ? cell_q[g] : cell_q[(g == DEPTH - 1) ? g : g + 1]),
      .q       (cell_q[g])
    );
  end

  // Hold count and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r <= count_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the result beat
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r   <= rd_data;
      out_status_r <= status;
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  assign out_bus.valid  = out_valid_r;
  assign out_bus.data   = out_data_r;
  assign out_bus.status = out_status_r;
  assign out_bus.count  = out_count_r;

  `BDQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "count exceeds depth")
  `BDQ_ASSERT_NOW(a_full_status, out_valid_r && (out_status_r == ST_FULL), count_r == CW'(DEPTH), "full status while not full")
  `BDQ_ASSERT_NEXT(a_push_count, fire && (ctl.wr || ctl.shr), count_r == $past(count_r) + 1'b1, "push did not grow count")
  `BDQ_ASSERT_NEXT(a_shl_count, fire && ctl.shl, count_r == $past(count_r) - 1'b1, "shift left did not shrink count")

endmodule
`default_nettype wire
